[hw/rtl/gregorian_day_number_converter_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Gregorian day number converter
// Short forms for the concurrent checks on the converter ports.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DAY_NUMBER_CONVERTER_TOP_ASSERT_SVH
`define GREGORIAN_DAY_NUMBER_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication, masked while reset is high
`define GDN_ASSERT_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("gdn check failed: same-cycle implication");

// next-cycle implication, masked while reset is high
`define GDN_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("gdn check failed: next-cycle implication");

// next-cycle implication that also holds through reset
`define GDN_ASSERT_NEXT_ALWAYS(label, clk, cond, expr) \
  label: assert property (@(posedge clk) (cond) |=> (expr)) \
    else $error("gdn check failed: next-cycle implication");

`endif

[hw/rtl/gdn_pkg.sv]
// ----------------------------------------------------------------------------
// gdn_pkg
// Types, constants and table functions shared by the converter pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdn_pkg;

  typedef enum logic {
    KIND_TO_DAYS = 1'b0,
    KIND_TO_DATE = 1'b1
  } kind_t;

  localparam logic [13:0] MAX_YEAR       = 14'd9999;
  localparam logic [3:0]  MONTHS         = 4'd12;
  localparam logic [3:0]  FEB            = 4'd2;
  localparam logic [3:0]  LAST_MONTH_IDX = 4'd11;
  localparam logic [8:0]  YEAR_DAYS      = 9'd365;
  localparam logic [8:0]  LEAP_YEAR_DAYS = 9'd366;
  localparam logic [8:0]  CYCLE_YEARS    = 9'd400;
  localparam logic [6:0]  CENTURY        = 7'd100;
  localparam logic [6:0]  LAST_OF_CENTURY = 7'd99;

  // y / 100 == (y * 5243) >> 19, exact for any 14-bit y
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  // x / 146097 == (x * CYCLE_RECIP) >> 49, exact for any 31-bit x
  localparam logic [31:0] CYCLE_RECIP = 32'd3853261556;
  localparam int          CYCLE_SHIFT = 49;

  // month estimate is floor(offset * 256 / 7787)
  localparam int MONTH_EST_DIV   = 7787;
  localparam int MONTH_EST_SCALE = 256;

  typedef struct packed {
    kind_t       kind;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [21:0] day_number;
  } req_t;

  typedef struct packed {
    kind_t       kind;
    logic        err;
    logic [21:0] day_count;
    logic [21:0] dn;
    logic [13:0] est;
  } front_t;

  typedef struct packed {
    kind_t       kind;
    logic        err;
    logic [21:0] day_count;
    logic [13:0] year;
    logic [8:0]  diff;
    logic        leap;
  } year_t;

  typedef struct packed {
    logic [21:0] day_number;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        range_error;
  } rsp_t;

  // days before the first of month idx+1 in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] idx);
    logic [8:0] d;
    unique case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // count the month boundaries of the estimate that the offset has passed
  function automatic logic [3:0] month_estimate(input logic [8:0] diff);
    logic [3:0] m;
    int         thr;
    m = 4'd0;
    for (int k = 1; k <= int'(LAST_MONTH_IDX); k++) begin
      thr = (k * MONTH_EST_DIV + MONTH_EST_SCALE - 1) / MONTH_EST_SCALE;
      if (int'(diff) >= thr) begin
        m = m + 4'd1;
      end
    end
    return m;
  endfunction

endpackage

[hw/rtl/gdn_if.sv]
// ----------------------------------------------------------------------------
// gdn_if
// Request and response channels of the converter, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gdn_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [13:0] in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic [21:0] day_number;

  modport source (output valid, kind, in_year, in_month, in_day, day_number,
                  input ready);
  modport sink (input valid, kind, in_year, in_month, in_day, day_number,
                output ready);
endinterface

interface gdn_rsp_if;
  logic        valid;
  logic        ready;
  logic [21:0] out_day_number;
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic        range_error;

  modport source (output valid, out_day_number, out_year, out_month, out_day,
                  range_error, input ready);
  modport sink (input valid, out_day_number, out_year, out_month, out_day,
                range_error, output ready);
endinterface

[hw/rtl/gregorian_day_number_converter_top.sv]
// ----------------------------------------------------------------------------
// gregorian_day_number_converter_top
// Proleptic Gregorian date to day count and back, day 0 being 0001-01-01.
//
// Requests come in on req (valid/ready). kind 0 takes in_year, in_month and
// in_day and returns out_day_number; kind 1 takes day_number and returns
// out_year, out_month and out_day. Fields not produced by a kind read zero.
// A bad month, a zero day, a year outside 1..9999, or a count that lands
// beyond year 9999 sets range_error with every other field zero.
// Responses leave on rsp in request order, one per request.
// One request per cycle is sustained while rsp is ready; the 31 x 32
// reciprocal multiply of the year estimate sets the depth of stage two.
// Each of the seven stages carries its own valid bit. A stalled rsp holds its
// result; upstream stages keep filling empty slots, so req stays ready until
// the pipe is full. A synchronous reset on rst empties the pipe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gregorian_day_number_converter_top (
  input  logic       clk,
  input  logic       rst,
  gdn_req_if.sink    req,
  gdn_rsp_if.source  rsp
);

  gdn_pkg::req_t   req_data;
  gdn_pkg::front_t front_data;
  gdn_pkg::year_t  year_data;
  gdn_pkg::rsp_t   rsp_data;

  logic front_valid;
  logic front_ready;
  logic year_valid;
  logic year_ready;

  always_comb begin
    req_data.kind       = gdn_pkg::kind_t'(req.kind);
    req_data.year       = req.in_year;
    req_data.month      = req.in_month;
    req_data.day        = req.in_day;
    req_data.day_number = req.day_number;
  end

  gdn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_req    (req_data),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  gdn_year_fix u_year_fix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (year_valid),
    .out_ready (year_ready),
    .out_data  (year_data)
  );

  gdn_month_day u_month_day (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (year_valid),
    .in_ready  (year_ready),
    .in_data   (year_data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp_data)
  );

  assign rsp.out_day_number = rsp_data.day_number;
  assign rsp.out_year       = rsp_data.year;
  assign rsp.out_month      = rsp_data.month;
  assign rsp.out_day        = rsp_data.day;
  assign rsp.range_error    = rsp_data.range_error;

endmodule

[hw/rtl/gdn_front.sv]
// ----------------------------------------------------------------------------
// gdn_front
// Stages 1-2: date to day count in full, and the 400-year year estimate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdn_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  gdn_pkg::req_t   in_req,
  output logic            out_valid,
  input  logic            out_ready,
  output gdn_pkg::front_t out_data
);

  logic vld1;
  logic vld2;
  logic ld1;
  logic ld2;

  assign ld2       = !vld2 || out_ready;
  assign ld1       = !vld1 || ld2;
  assign in_ready  = ld1;
  assign out_valid = vld2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      if (ld1) vld1 <= in_valid;
      if (ld2) vld2 <= vld1;
    end
  end

  // stage 1
  gdn_pkg::kind_t s1_kind;
  logic           s1_err;
  logic [13:0]    s1_y;
  logic [26:0]    s1_ymul;
  logic [22:0]    s1_base;
  logic [30:0]    s1_x;
  logic [21:0]    s1_dn;

  logic        month_bad;
  logic        date_bad;
  logic [13:0] y_adj;
  logic [22:0] base;
  logic [30:0] x;
  logic [26:0] ymul;

  always_comb begin
    month_bad = (in_req.month == 4'd0) || (in_req.month > gdn_pkg::MONTHS);
    date_bad  = month_bad || (in_req.day == 5'd0) || (in_req.year == 14'd0) ||
                (in_req.year > gdn_pkg::MAX_YEAR);
    // January and February fall before this year's leap day
    y_adj = (in_req.month <= gdn_pkg::FEB) ? in_req.year - 14'd1 : in_req.year;
    base  = 23'(in_req.year) * 23'(gdn_pkg::YEAR_DAYS) +
            23'(gdn_pkg::cum_days(in_req.month - 4'd1)) + 23'(in_req.day);
    x     = 31'({1'b0, in_req.day_number} + 23'(gdn_pkg::YEAR_DAYS)) *
            31'(gdn_pkg::CYCLE_YEARS);
    ymul  = 27'(y_adj) * 27'(gdn_pkg::DIV100_MUL);
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_kind <= in_req.kind;
      s1_err  <= (in_req.kind == gdn_pkg::KIND_TO_DAYS) && date_bad;
      s1_y    <= y_adj;
      s1_ymul <= ymul;
      s1_base <= base;
      s1_x    <= x;
      s1_dn   <= in_req.day_number;
    end
  end

  // stage 2
  logic [7:0]  y100;
  logic [23:0] count;
  logic [62:0] prod;

  always_comb begin
    y100  = s1_ymul[gdn_pkg::DIV100_SHIFT +: 8];
    count = 24'(s1_base) + 24'(s1_y[13:2]) - 24'(y100) + 24'(y100[7:2]) -
            24'(gdn_pkg::LEAP_YEAR_DAYS);
    prod  = 63'(s1_x) * 63'(gdn_pkg::CYCLE_RECIP);
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      out_data.kind      <= s1_kind;
      out_data.err       <= s1_err;
      out_data.day_count <= count[21:0];
      out_data.dn        <= s1_dn;
      out_data.est       <= prod[gdn_pkg::CYCLE_SHIFT +: 14];
    end
  end

endmodule

[hw/rtl/gdn_year_fix.sv]
// ----------------------------------------------------------------------------
// gdn_year_fix
// Stages 3-5: days before the estimated year, offset and one-year correction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdn_year_fix (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  gdn_pkg::front_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output gdn_pkg::year_t  out_data
);

  logic vld3;
  logic vld4;
  logic vld5;
  logic ld3;
  logic ld4;
  logic ld5;

  assign ld5       = !vld5 || out_ready;
  assign ld4       = !vld4 || ld5;
  assign ld3       = !vld3 || ld4;
  assign in_ready  = ld3;
  assign out_valid = vld5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
    end else begin
      if (ld3) vld3 <= in_valid;
      if (ld4) vld4 <= vld3;
      if (ld5) vld5 <= vld4;
    end
  end

  // stage 3: divide the estimate and the year before it by 100
  gdn_pkg::kind_t s3_kind;
  logic           s3_err;
  logic [21:0]    s3_day_count;
  logic [21:0]    s3_dn;
  logic [13:0]    s3_est;
  logic           s3_est_zero;
  logic [13:0]    s3_p;
  logic [26:0]    s3_pmul;
  logic [26:0]    s3_emul;

  logic        est_zero;
  logic [13:0] p;

  always_comb begin
    est_zero = (in_data.est == 14'd0);
    p        = est_zero ? 14'd0 : in_data.est - 14'd1;
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_kind      <= in_data.kind;
      s3_err       <= in_data.err;
      s3_day_count <= in_data.day_count;
      s3_dn        <= in_data.dn;
      s3_est       <= in_data.est;
      s3_est_zero  <= est_zero;
      s3_p         <= p;
      s3_pmul      <= 27'(p) * 27'(gdn_pkg::DIV100_MUL);
      s3_emul      <= 27'(in_data.est) * 27'(gdn_pkg::DIV100_MUL);
    end
  end

  // stage 4: offset into the estimated year, leap flags of it and the next
  gdn_pkg::kind_t s4_kind;
  logic           s4_err;
  logic [21:0]    s4_day_count;
  logic [13:0]    s4_est;
  logic [9:0]     s4_diff;
  logic           s4_leap0;
  logic           s4_leap1;

  logic [7:0]  p100;
  logic [7:0]  e100;
  logic [22:0] dbase;
  logic [22:0] dstart;
  logic [23:0] diff_full;
  logic [13:0] e_rem_full;
  logic [6:0]  e_rem;
  logic        leap0;
  logic        leap1;

  always_comb begin
    p100  = s3_pmul[gdn_pkg::DIV100_SHIFT +: 8];
    e100  = s3_emul[gdn_pkg::DIV100_SHIFT +: 8];
    // days before the year, offset by one leap year so year zero reads as 0
    dbase = 23'(s3_p) * 23'(gdn_pkg::YEAR_DAYS) + 23'(s3_p[13:2]) - 23'(p100) +
            23'(p100[7:2]) + 23'(gdn_pkg::LEAP_YEAR_DAYS);
    dstart     = s3_est_zero ? 23'd0 : dbase;
    diff_full  = 24'(s3_dn) + 24'(gdn_pkg::LEAP_YEAR_DAYS) - 24'(dstart);
    e_rem_full = s3_est - 14'(e100) * 14'(gdn_pkg::CENTURY);
    e_rem      = e_rem_full[6:0];
    leap0 = (s3_est[1:0] == 2'd0) && ((e_rem != 7'd0) || (e100[1:0] == 2'd0));
    // next year: ends a century when this one is the last of its century
    leap1 = (s3_est[1:0] == 2'd3) &&
            ((e_rem != gdn_pkg::LAST_OF_CENTURY) || (e100[1:0] == 2'd3));
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_kind      <= s3_kind;
      s4_err       <= s3_err;
      s4_day_count <= s3_day_count;
      s4_est       <= s3_est;
      s4_diff      <= diff_full[9:0];
      s4_leap0     <= leap0;
      s4_leap1     <= leap1;
    end
  end

  // stage 5: advance one year when the offset runs past the year's length
  logic [9:0]  ylen;
  logic        bump;
  logic [9:0]  diff_fixed;
  logic [13:0] year;

  always_comb begin
    ylen       = s4_leap0 ? 10'(gdn_pkg::LEAP_YEAR_DAYS) : 10'(gdn_pkg::YEAR_DAYS);
    bump       = (s4_diff >= ylen);
    diff_fixed = bump ? s4_diff - ylen : s4_diff;
    year       = bump ? s4_est + 14'd1 : s4_est;
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      out_data.kind      <= s4_kind;
      out_data.err       <= (s4_kind == gdn_pkg::KIND_TO_DAYS) ? s4_err :
                            (year > gdn_pkg::MAX_YEAR);
      out_data.day_count <= s4_day_count;
      out_data.year      <= year;
      out_data.diff      <= diff_fixed[8:0];
      out_data.leap      <= bump ? s4_leap1 : s4_leap0;
    end
  end

endmodule

[hw/rtl/gdn_month_day.sv]
// ----------------------------------------------------------------------------
// gdn_month_day
// Stages 6-7: month estimate, one-month correction, day and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdn_month_day (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gdn_pkg::year_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output gdn_pkg::rsp_t  out_data
);

  logic vld6;
  logic vld7;
  logic ld6;
  logic ld7;

  assign ld7       = !vld7 || out_ready;
  assign ld6       = !vld6 || ld7;
  assign in_ready  = ld6;
  assign out_valid = vld7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld6 <= 1'b0;
      vld7 <= 1'b0;
    end else begin
      if (ld6) vld6 <= in_valid;
      if (ld7) vld7 <= vld6;
    end
  end

  // stage 6
  gdn_pkg::year_t s6;
  logic [3:0]     s6_m;

  always_ff @(posedge clk) begin
    if (ld6) begin
      s6   <= in_data;
      s6_m <= gdn_pkg::month_estimate(in_data.diff);
    end
  end

  // stage 7
  logic [9:0]    thr;
  logic          bump;
  logic [3:0]    m;
  logic          leap_eff;
  logic [9:0]    day_full;
  gdn_pkg::rsp_t rsp;

  always_comb begin
    // January's end carries no leap day
    thr  = 10'(gdn_pkg::cum_days(s6_m + 4'd1)) + 10'((s6_m != 4'd0) && s6.leap);
    bump = (s6_m < gdn_pkg::LAST_MONTH_IDX) && (10'(s6.diff) >= thr);
    m    = bump ? s6_m + 4'd1 : s6_m;
    leap_eff = (m >= gdn_pkg::FEB) && s6.leap;
    day_full = 10'(s6.diff) - 10'(gdn_pkg::cum_days(m)) - 10'(leap_eff) + 10'd1;

    rsp = '0;
    if (s6.err) begin
      rsp.range_error = 1'b1;
    end else if (s6.kind == gdn_pkg::KIND_TO_DAYS) begin
      rsp.day_number = s6.day_count;
    end else begin
      rsp.year  = s6.year;
      rsp.month = m + 4'd1;
      rsp.day   = day_full[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld7) out_data <= rsp;
  end

endmodule

[hw/rtl/gdn_checker.sv]
// ----------------------------------------------------------------------------
// gdn_checker
// Port-level checks on the converter response channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gregorian_day_number_converter_top_assert.svh"

module gdn_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [21:0] out_day_number,
  input logic [13:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day,
  input logic        range_error
);

  // hold a stalled result unchanged
  `GDN_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
    rsp_valid && $stable(out_day_number) && $stable(out_year) &&
    $stable(out_month) && $stable(out_day) && $stable(range_error))

  // an error result carries nothing else
  `GDN_ASSERT_IMPLY(a_err_zero, clk, rst, rsp_valid && range_error,
    out_day_number == 22'd0 && out_year == 14'd0 && out_month == 4'd0 &&
    out_day == 5'd0)

  // a date result is a whole, valid date and no day count
  `GDN_ASSERT_IMPLY(a_date_shape, clk, rst, rsp_valid && out_month != 4'd0,
    out_month <= 4'd12 && out_day != 5'd0 && out_year != 14'd0 &&
    out_day_number == 22'd0 && !range_error)

  // reset empties the pipe
  `GDN_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !rsp_valid)

endmodule

bind gregorian_day_number_converter_top gdn_checker u_gdn_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .out_day_number (rsp.out_day_number),
  .out_year       (rsp.out_year),
  .out_month      (rsp.out_month),
  .out_day        (rsp.out_day),
  .range_error    (rsp.range_error)
);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Gregorian day number converter: a directed set
// of calendar edge cases, then random dates and day counts with random
// gaps and back-pressure on both channels, checked in order against a
// behavioural calendar model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import gdn_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 30;

  // first day of each month, counted from 1 January of a common year
  localparam longint MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243,
                                          273, 304, 334};

  function automatic bit leap_year(longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // days from 0001-01-01 up to 1 January of year y
  function automatic longint year_start(longint y);
    longint p;
    if (y <= 0) begin
      return -366;
    end
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  class date_scoreboard;
    rsp_t pending[$];
    int   errors;

    function rsp_t convert(req_t r);
      rsp_t   res;
      longint yr, mo, dy, y, dn, est, diff, ylen, leap, m;
      res = '0;
      if (r.kind == KIND_TO_DAYS) begin
        yr = r.year;
        mo = r.month;
        dy = r.day;
        if (mo < 1 || mo > 12 || dy < 1 || yr < 1 || yr > MAX_YEAR) begin
          res.range_error = 1'b1;
          return res;
        end
        // January and February belong to the leap count of the year before
        y = (mo <= 2) ? yr - 1 : yr;
        res.day_number = 22'(yr * 365 + y / 4 - y / 100 + y / 400
                             + MONTH_START[mo - 1] + dy - 366);
      end else begin
        dn   = r.day_number;
        est  = (dn + 365) * 400 / 146097;
        diff = dn - year_start(est);
        ylen = leap_year(est) ? 366 : 365;
        if (diff >= ylen) begin
          est++;
          diff -= ylen;
        end
        if (est > MAX_YEAR) begin
          res.range_error = 1'b1;
          return res;
        end
        leap = leap_year(est) ? 1 : 0;
        m = diff * 256 / 7787;
        if (m > 11) begin
          m = 11;
        end
        if (m < 1) begin
          if (diff >= MONTH_START[1]) m++;
        end else if (m < 11) begin
          if (diff >= MONTH_START[m + 1] + leap) m++;
        end
        if (m < 2) begin
          leap = 0;
        end
        res.year  = 14'(est);
        res.month = 4'(m + 1);
        res.day   = 5'(diff - MONTH_START[m] - leap + 1);
      end
      return res;
    endfunction

    function void note_request(req_t r);
      pending.push_back(convert(r));
    endfunction

    function void compare_field(string field, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        $display("%0t: response with no request outstanding, expected none, actual %p",
                 $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("out_day_number", want.day_number, got.day_number);
      compare_field("out_year", want.year, got.year);
      compare_field("out_month", want.month, got.month);
      compare_field("out_day", want.day, got.day);
      compare_field("range_error", want.range_error, got.range_error);
    endfunction
  endclass

  logic clk;
  logic rst;

  gdn_req_if req ();
  gdn_rsp_if rsp ();

  gregorian_day_number_converter_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  date_scoreboard sb;
  bit             send_steady;
  bit             take_steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // note accepted requests before checking responses taken at the same edge
  always @(posedge clk) begin
    req_t rq;
    rsp_t rs;
    if (!rst) begin
      if (req.valid && req.ready) begin
        rq.kind       = kind_t'(req.kind);
        rq.year       = req.in_year;
        rq.month      = req.in_month;
        rq.day        = req.in_day;
        rq.day_number = req.day_number;
        sb.note_request(rq);
      end
      if (rsp.valid && rsp.ready) begin
        rs.day_number  = rsp.out_day_number;
        rs.year        = rsp.out_year;
        rs.month       = rsp.out_month;
        rs.day         = rsp.out_day;
        rs.range_error = rsp.range_error;
        sb.check_response(rs);
      end
    end
  end

  function automatic req_t make_req(kind_t k, int y, int m, int d, int dn);
    req_t r;
    r.kind       = k;
    r.year       = 14'(y);
    r.month      = 4'(m);
    r.day        = 5'(d);
    r.day_number = 22'(dn);
    return r;
  endfunction

  function automatic req_t random_request();
    req_t   r;
    longint dn;
    int     pick;
    r.year       = 14'($urandom);
    r.month      = 4'($urandom);
    r.day        = 5'($urandom);
    r.day_number = 22'($urandom);
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) begin
      r.kind = KIND_TO_DAYS;
      if (pick < 85) begin
        r.year  = 14'($urandom_range(1, 9999));
        r.month = 4'($urandom_range(1, 12));
        r.day   = 5'($urandom_range(1, 31));
      end
    end else begin
      r.kind = KIND_TO_DATE;
      if (pick < 75) begin
        r.day_number = 22'($urandom_range(0, 3652058));
      end else if (pick < 90) begin
        // land on either side of a new year, the top year included
        dn = year_start($urandom_range(1, 10000)) + $urandom_range(0, 2) - 1;
        if (dn < 0) dn = 0;
        r.day_number = 22'(dn);
      end
    end
    return r;
  endfunction

  task automatic drive_request(input req_t r);
    int gap;
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.kind       <= r.kind;
    req.in_year    <= r.year;
    req.in_month   <= r.month;
    req.in_day     <= r.day;
    req.day_number <= r.day_number;
    do @(posedge clk); while (!req.ready);
  endtask

  // response side: random stalls, plus two long hold-offs to fill the pipe
  initial begin
    int hold;
    int taken;
    taken = 0;
    rsp.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) take_steady = !take_steady;
      if (taken == 30 || taken == 1000) begin
        hold = LONG_HOLD;
      end else begin
        hold = take_steady ? 0 : $urandom_range(0, 18);
      end
      if (hold > 0) begin
        rsp.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      taken++;
    end
  end

  initial begin
    req_t directed[$];
    req.valid      <= 1'b0;
    req.kind       <= KIND_TO_DAYS;
    req.in_year    <= '0;
    req.in_month   <= '0;
    req.in_day     <= '0;
    req.day_number <= '0;

    directed.push_back(make_req(KIND_TO_DAYS, 1, 1, 1, 0));
    directed.push_back(make_req(KIND_TO_DAYS, 9999, 12, 31, 4194303));
    directed.push_back(make_req(KIND_TO_DAYS, 2000, 2, 29, 0));
    directed.push_back(make_req(KIND_TO_DAYS, 1900, 2, 29, 0));
    directed.push_back(make_req(KIND_TO_DAYS, 2001, 2, 31, 0));
    directed.push_back(make_req(KIND_TO_DAYS, 2023, 4, 31, 0));
    directed.push_back(make_req(KIND_TO_DAYS, 400, 12, 31, 0));
    directed.push_back(make_req(KIND_TO_DAYS, 1600, 3, 1, 0));
    directed.push_back(make_req(KIND_TO_DAYS, 1, 0, 1, 0));
    directed.push_back(make_req(KIND_TO_DAYS, 1, 13, 1, 0));
    directed.push_back(make_req(KIND_TO_DAYS, 16383, 15, 31, 4194303));
    directed.push_back(make_req(KIND_TO_DAYS, 5, 6, 0, 0));
    directed.push_back(make_req(KIND_TO_DAYS, 0, 1, 1, 0));
    directed.push_back(make_req(KIND_TO_DAYS, 10000, 1, 1, 0));
    directed.push_back(make_req(KIND_TO_DATE, 0, 0, 0, 0));
    directed.push_back(make_req(KIND_TO_DATE, 16383, 15, 31, 58));
    directed.push_back(make_req(KIND_TO_DATE, 0, 0, 0, 59));
    directed.push_back(make_req(KIND_TO_DATE, 0, 0, 0, 364));
    directed.push_back(make_req(KIND_TO_DATE, 0, 0, 0, 365));
    directed.push_back(make_req(KIND_TO_DATE, 0, 0, 0, 146096));
    directed.push_back(make_req(KIND_TO_DATE, 0, 0, 0, 146097));
    directed.push_back(make_req(KIND_TO_DATE, 0, 0, 0, 730178));
    directed.push_back(make_req(KIND_TO_DATE, 0, 0, 0, 3652058));
    directed.push_back(make_req(KIND_TO_DATE, 0, 0, 0, 3652059));
    directed.push_back(make_req(KIND_TO_DATE, 0, 0, 0, 4194303));

    do @(posedge clk); while (rst);
    foreach (directed[i]) drive_request(directed[i]);
    repeat (RANDOM_ITEMS) drive_request(random_request());
    req.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    // catch any stray response after the last one expected
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
